### rtl/deque_with_sorted_insert_unit_defines.svh
// Assertion macros for the deque with sorted insert.
`ifndef DEQUE_WITH_SORTED_INSERT_UNIT_DEFINES_SVH
`define DEQUE_WITH_SORTED_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error(msg);

`endif

### rtl/dwsi_pkg.sv
// Package: sizes, command and status codes, sequencer states for the deque.
`default_nettype none
package dwsi_pkg;
  localparam int CAPACITY = 16;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int REC_W    = KEY_W + PAY_W;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 2;
  localparam int TOT_W    = 5;
  localparam int DATA_W   = 72;

  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;
  localparam cmd_t CMD_SORTED     = 3'd4;

  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/dwsi_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module dwsi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic      [WIDTH-1:0]           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/deque_with_sorted_insert_unit.sv
// Deque with sorted insert: circular record RAM under a small sequencer.
// Pushes, rejected and unknown commands go from dispatch to done; pops pass a wait state before done.
// Sorted insert: scan read/compare steps over the n stored records until a greater key, then shift read/write steps.
// s_tready is high only in idle, so one command is in flight at a time; one RAM access a cycle.
// Synchronous reset clears count, head pointer, sequencer and output valid.
// Record RAM is not cleared; only entries below the count are ever used.
`default_nettype none
`include "deque_with_sorted_insert_unit_defines.svh"
module deque_with_sorted_insert_unit
  import dwsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // command[2:0], item_key[34:3], item_payload[66:35], zero[71:67]
  input  wire logic [DATA_W-1:0] s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // status[1:0], out_valid[2], out_key[34:3], out_payload[66:35], entry_total[71:67]
  output logic      [DATA_W-1:0] m_tdata
);
  state_t state, state_next;

  logic [CW-1:0] cnt;
  logic [AW-1:0] head;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;

  cmd_t                    cmd_r;
  logic signed [KEY_W-1:0] key_r;
  logic [PAY_W-1:0]        pay_r;

  status_t          res_status;
  logic             res_valid;
  logic [KEY_W-1:0] res_key;
  logic [PAY_W-1:0] res_pay;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] ram_rdata;

  logic [CW-1:0] lidx;
  logic [CW:0]   sum;
  logic [CW:0]   phys;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          empty;
  logic          key_gt;
  logic          out_free;

  assign full     = (cnt >= CW'(CAPACITY));
  assign empty    = (cnt == '0);
  assign key_gt   = ($signed(ram_rdata[REC_W-1:PAY_W]) > key_r);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  assign head_dec = (head == '0) ? AW'(CAPACITY - 1) : head - AW'(1);
  assign head_inc = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);

  // logical index to RAM address
  always_comb begin
    case (state)
      S_DISPATCH: begin
        if (cmd_r == CMD_POP_FRONT) begin
          lidx = '0;
        end else if (cmd_r == CMD_POP_BACK) begin
          lidx = cnt - CW'(1);
        end else begin
          lidx = cnt;
        end
      end
      S_SCAN_RD:  lidx = idx;
      S_SHIFT_RD: lidx = (idx == pos) ? pos : idx - CW'(1);
      S_SHIFT_WR: lidx = idx;
      default:    lidx = '0;
    endcase
  end

  assign sum  = (CW+1)'(head) + (CW+1)'(lidx);
  assign phys = (sum >= (CW+1)'(CAPACITY)) ? sum - (CW+1)'(CAPACITY) : sum;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = {key_r, pay_r};
    ram_addr   = phys[AW-1:0];
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (cmd_r)
          CMD_PUSH_FRONT: begin
            ram_addr   = head_dec;
            ram_we     = !full;
            state_next = S_DONE;
          end
          CMD_PUSH_BACK: begin
            ram_we     = !full;
            state_next = S_DONE;
          end
          CMD_SORTED: begin
            state_next = full ? S_DONE : S_SCAN_RD;
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            state_next = empty ? S_DONE : S_POP_WAIT;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_POP_WAIT: begin
        state_next = S_DONE;
      end
      S_SCAN_RD: begin
        state_next = (idx == cnt) ? S_SHIFT_RD : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_next = key_gt ? S_SHIFT_RD : S_SCAN_RD;
      end
      S_SHIFT_RD: begin
        if (idx == pos) begin
          ram_we     = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = S_SHIFT_RD;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      head     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r      <= s_tdata[2:0];
            key_r      <= s_tdata[34:3];
            pay_r      <= s_tdata[66:35];
            res_status <= ST_OK;
            res_valid  <= 1'b0;
            res_key    <= '0;
            res_pay    <= '0;
          end
        end
        S_DISPATCH: begin
          case (cmd_r)
            CMD_PUSH_FRONT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                head <= head_dec;
                cnt  <= cnt + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                cnt <= cnt + CW'(1);
              end
            end
            CMD_SORTED: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                idx <= '0;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                if (cmd_r == CMD_POP_FRONT) begin
                  head <= head_inc;
                end
                cnt       <= cnt - CW'(1);
                res_valid <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_POP_WAIT: begin
          res_key <= ram_rdata[REC_W-1:PAY_W];
          res_pay <= ram_rdata[PAY_W-1:0];
        end
        S_SCAN_RD: begin
          if (idx == cnt) begin
            pos <= idx;
            idx <= cnt;
          end
        end
        S_SCAN_CMP: begin
          if (key_gt) begin
            pos <= idx;
            idx <= cnt;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHIFT_RD: begin
          if (idx == pos) begin
            cnt <= cnt + CW'(1);
          end
        end
        S_SHIFT_WR: begin
          idx <= idx - CW'(1);
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {TOT_W'(cnt), res_pay, res_key, res_valid, res_status};
          end
        end
        default: begin
        end
      endcase
    end
  end

  dwsi_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  `ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt <= CW'(CAPACITY), "count above capacity")
  `ASSERT_IMPLIES(a_head_bound, 1'b1, (CW+1)'(head) < (CW+1)'(CAPACITY), "head out of range")
  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `ASSERT_IMPLIES(a_pop_ok, m_tvalid && m_tdata[2], m_tdata[1:0] == ST_OK, "record with error")
  `ASSERT_IMPLIES(a_shift_range, state == S_SHIFT_RD || state == S_SHIFT_WR, idx >= pos && idx <= cnt, "shift index out of range")
endmodule
`default_nettype wire

### tb/deque_result_checker.sv
// Checker for the deque: predicts each result from accepted commands and compares.
`default_nettype none
module deque_result_checker
  import dwsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,
  input  wire logic              m_tvalid,
  input  wire logic              m_tready,
  input  wire logic [DATA_W-1:0] m_tdata,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } stored_rec_t;

  typedef struct packed {
    status_t                 status;
    logic                    out_valid;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic [TOT_W-1:0]        total;
  } deque_result_t;

  stored_rec_t   held_recs[$];
  deque_result_t pending_results[$];

  function automatic deque_result_t apply_command(cmd_t c, logic signed [KEY_W-1:0] k,
                                                  logic [PAY_W-1:0] p);
    deque_result_t r;
    stored_rec_t   rec;
    int            pos;
    r = '0;
    rec.key = k;
    rec.payload = p;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED: begin
        if (held_recs.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (c == CMD_PUSH_FRONT) begin
          held_recs.push_front(rec);
        end else if (c == CMD_PUSH_BACK) begin
          held_recs.push_back(rec);
        end else begin
          // ahead of the first strictly greater key; equal keys keep arrival order
          pos = 0;
          while (pos < held_recs.size() && !(held_recs[pos].key > k)) pos++;
          held_recs.insert(pos, rec);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (held_recs.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          rec = (c == CMD_POP_FRONT) ? held_recs.pop_front() : held_recs.pop_back();
          r.out_valid = 1'b1;
          r.key       = rec.key;
          r.payload   = rec.payload;
        end
      end
      default: begin
      end
    endcase
    r.status = (r.status == ST_FULL || r.status == ST_EMPTY) ? r.status : ST_OK;
    r.total  = TOT_W'(held_recs.size());
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    logic          bad;
    if (rst) begin
      held_recs.delete();
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_command(s_tdata[2:0], s_tdata[34:3], s_tdata[66:35]));
      end
      if (m_tvalid && m_tready) begin
        got.status    = m_tdata[1:0];
        got.out_valid = m_tdata[2];
        got.key       = m_tdata[34:3];
        got.payload   = m_tdata[66:35];
        got.total     = m_tdata[71:67];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          bad  = 1'b0;
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            bad = 1'b1;
          end
          if (got.out_valid !== want.out_valid) begin
            $display("%0t: out_valid expected %0d actual %0d", $time, want.out_valid,
                     got.out_valid);
            bad = 1'b1;
          end
          if (got.key !== want.key) begin
            $display("%0t: out_key expected %0d actual %0d", $time, want.key, got.key);
            bad = 1'b1;
          end
          if (got.payload !== want.payload) begin
            $display("%0t: out_payload expected %h actual %h", $time, want.payload,
                     got.payload);
            bad = 1'b1;
          end
          if (got.total !== want.total) begin
            $display("%0t: entry_total expected %0d actual %0d", $time, want.total, got.total);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    pending = pending_results.size();
  end

endmodule
`default_nettype wire

### tb/tb.sv
// Testbench top: clock, reset, command stimulus, result back-pressure and verdict.
`default_nettype none
module tb;
  import dwsi_pkg::*;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  // command[2:0], item_key[34:3], item_payload[66:35], zero[71:67]
  logic [DATA_W-1:0] s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  // status[1:0], out_valid[2], out_key[34:3], out_payload[66:35], entry_total[71:67]
  logic [DATA_W-1:0] m_tdata;
  int                fail_count;
  int                pending;

  bit                sender_idle;
  bit                hold_req;
  bit                hold_done;
  int                hold_left;
  int                rx_cycle;

  deque_with_sorted_insert_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deque_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // result side: random back-pressure, one long hold-off on request, one quiet stretch
  initial begin
    m_tready  = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    rx_cycle  = 0;
    forever begin
      @(posedge clk);
      if (!rst) rx_cycle++;
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else if (rx_cycle >= 3000 && rx_cycle < 8000) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic send_cmd(input cmd_t c, input logic [KEY_W-1:0] k,
                          input logic [PAY_W-1:0] p);
    if (sender_idle) begin
      while ($urandom_range(99) < 14) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, p, k, c};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic await_drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return $urandom_range(10) - 5;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int   n;
    int   r;
    int   burst_left;
    bit   filling;
    cmd_t c;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    hold_req    = 1'b0;
    sender_idle = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, unknown commands, key extremes, equal keys, then fill and overflow
    send_cmd(CMD_POP_FRONT, '1, '1);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(cmd_t'(5), '1, '1);
    send_cmd(cmd_t'(7), '0, '0);
    send_cmd(CMD_SORTED, 32'd0, 32'h0000_0000);
    send_cmd(CMD_SORTED, 32'h7fff_ffff, 32'hffff_ffff);
    send_cmd(CMD_SORTED, 32'h8000_0000, 32'h1234_5678);
    send_cmd(CMD_SORTED, 32'd0, 32'hcafe_0001);
    send_cmd(CMD_PUSH_FRONT, 32'hffff_ffff, 32'h5555_aaaa);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff, 32'haaaa_5555);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    for (n = 0; n < 12; n++) begin
      c = (n % 3 == 0) ? CMD_PUSH_FRONT : (n % 3 == 1) ? CMD_PUSH_BACK : CMD_SORTED;
      send_cmd(c, pick_key(), pick_payload());
    end
    send_cmd(CMD_PUSH_BACK, 32'h0000_0001, '1);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000, '0);
    send_cmd(CMD_SORTED, 32'd0, 32'h0bad_f00d);
    await_drain();

    burst_left = 0;
    filling    = 1'b1;
    for (n = 0; n < 1500; n++) begin
      if (burst_left == 0) begin
        filling    = 1'($urandom_range(1));
        burst_left = $urandom_range(40, 8);
      end
      burst_left--;
      sender_idle = !(n >= 400 && n < 700);
      if (n == 300) hold_req <= 1'b1;
      if (n == 1000) await_drain();
      r = $urandom_range(99);
      if (r < 3) begin
        c = cmd_t'($urandom_range(7, 5));
      end else if ((r < 80) == filling) begin
        case ($urandom_range(3))
          0:       c = CMD_PUSH_FRONT;
          1:       c = CMD_PUSH_BACK;
          default: c = CMD_SORTED;
        endcase
      end else begin
        c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_cmd(c, pick_key(), pick_payload());
    end

    await_drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
